FILE: rtl/core/track_point_time_interpolator_defines.svh
// Assertion macros used by the track point interpolator datapath.
`ifndef TRACK_POINT_TIME_INTERPOLATOR_DEFINES_SVH
`define TRACK_POINT_TIME_INTERPOLATOR_DEFINES_SVH

// Check a property on every clock edge outside reset.
`define TPTI_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Check that a condition implies a consequence in the same cycle.
`define TPTI_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

`endif

FILE: rtl/core/tpti_pkg.sv
package tpti_pkg;

	localparam logic [2:0] MODE_NONE = 3'd0;
	localparam logic [2:0] MODE_NN   = 3'd1;
	localparam logic [2:0] MODE_LIN  = 3'd2;
	localparam logic [2:0] MODE_REL  = 3'd3;
	localparam logic [2:0] MODE_ABS  = 3'd4;

	localparam logic CFG_MODE  = 1'b0;
	localparam logic CFG_LIMIT = 1'b1;

	localparam logic OP_APPEND = 1'b0;
	localparam logic OP_QUERY  = 1'b1;

	localparam logic DIV_FACTOR = 1'b0;
	localparam logic DIV_LIMIT  = 1'b1;

	localparam int NUM_W = 49;
	localparam int DEN_W = 32;
	localparam int Q_W   = 24;

	localparam logic [23:0] LIMIT_RST = 24'd65536;

	localparam logic signed [17:0] OUT_MIN = -18'sd65536;
	localparam logic signed [17:0] OUT_MAX = 18'sd131071;

	typedef struct packed {
		logic append;
		logic q_start;
		logic k_clr;
		logic k_inc;
		logic res_zero;
		logic ld_new;
		logic nn_init;
		logic nn_take;
		logic ld_prev;
		logic prep;
		logic div_start;
		logic div_sel;
		logic ld_f;
		logic lim_cfg;
		logic ld_lim;
		logic f_zero;
		logic clamp;
		logic mul_x;
		logic mul_y;
		logic app_x;
		logic app_y;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic       cnt_zero;
		logic       cnt_lt2;
		logic [2:0] mode;
		logic       nn_stop;
		logic       nn_last;
		logic       dt_zero;
		logic       div_busy;
		logic       out_free;
	} sts_t;

endpackage

FILE: rtl/core/tpti_ram.sv
module tpti_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

FILE: rtl/core/tpti_div.sv
module tpti_div import tpti_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [NUM_W-1:0] num,
	input  logic [DEN_W-1:0] den,
	output logic             busy,
	output logic [Q_W-1:0]   quo
);

	logic             busy_q;
	logic [4:0]       cnt_q;
	logic [DEN_W-1:0] rem_q;
	logic [DEN_W-1:0] den_q;
	logic [Q_W-1:0]   sh_q;
	logic             sat;
	logic [DEN_W:0]   trial;
	logic             take;

	// quotient of 2^24 or more saturates at once
	assign sat   = {{(DEN_W + Q_W - NUM_W){1'b0}}, num} >= {den, {Q_W{1'b0}}};
	assign trial = {rem_q, sh_q[Q_W-1]};
	assign take  = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= !sat;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 5'd1;
			if (cnt_q == 5'(Q_W - 1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			den_q <= den;
			if (sat) begin
				sh_q <= '1;
			end else begin
				rem_q <= DEN_W'(num[NUM_W-1:Q_W]);
				sh_q  <= num[Q_W-1:0];
			end
		end else if (busy_q) begin
			// shift one numerator bit into the remainder and one quotient bit into sh_q
			rem_q <= take ? DEN_W'(trial - {1'b0, den_q}) : trial[DEN_W-1:0];
			sh_q  <= {sh_q[Q_W-2:0], take};
		end
	end

	assign busy = busy_q;
	assign quo  = sh_q;

endmodule

FILE: rtl/core/tpti_dpath.sv
`include "track_point_time_interpolator_defines.svh"
module tpti_dpath import tpti_pkg::*; #(
	parameter int HIST_DEPTH = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  cmd_t        cmd,
	output sts_t        sts,
	input  logic [63:0] s_tdata,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [23:0] cfg_data,
	input  logic        m_tready,
	output logic        m_tvalid,
	output logic [39:0] m_tdata
);

	localparam int AW = $clog2(HIST_DEPTH);
	localparam int CW = $clog2(HIST_DEPTH + 1);
	localparam int SW = $clog2(2 * HIST_DEPTH);

	logic [2:0]  mode_q;
	logic [23:0] limit_q;
	logic [AW-1:0] head_q;
	logic [CW-1:0] cnt_q;
	logic [AW-1:0] k_q;
	logic [AW-1:0] k_d;
	logic [SW-1:0] slot;
	logic [AW-1:0] raddr;
	logic [63:0]   rdata;
	logic [31:0]   rd_t;
	logic [15:0]   rd_x;
	logic [15:0]   rd_y;
	logic [31:0]   d_now;

	logic [31:0] tq_q;
	logic [31:0] ct_q;
	logic [15:0] cx_q;
	logic [15:0] cy_q;
	logic [31:0] best_q;
	logic signed [17:0] res_x_q;
	logic signed [17:0] res_y_q;
	logic               res_v_q;
	logic signed [32:0] dt_q;
	logic signed [32:0] dq_q;
	logic signed [16:0] dx_q;
	logic signed [16:0] dy_q;
	logic [31:0] adt_q;
	logic [31:0] adq_q;
	logic        fneg_q;
	logic        dtneg_q;
	logic signed [25:0] f_q;
	logic signed [25:0] lim_q;
	logic signed [25:0] lo;
	logic signed [42:0] p_s1;
	logic [NUM_W-1:0] div_num;
	logic             div_busy;
	logic [Q_W-1:0]   div_quo;
	logic signed [25:0] q_ext;
	logic        m_tvalid_q;
	logic [39:0] m_tdata_q;

	function automatic logic signed [17:0] apply(input logic signed [42:0] p,
			input logic [15:0] cur);
		logic [42:0] ap;
		logic [26:0] mag;
		logic signed [28:0] r;
		logic signed [28:0] v;
		ap  = p[42] ? 43'(-p) : 43'(p);
		mag = 27'((ap + 43'd32768) >> 16);
		r   = $signed({2'b00, mag});
		v   = $signed({13'b0, cur}) + (p[42] ? -r : r);
		if (v < OUT_MIN) begin
			apply = OUT_MIN;
		end else if (v > OUT_MAX) begin
			apply = OUT_MAX;
		end else begin
			apply = v[17:0];
		end
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= MODE_NONE;
			limit_q <= LIMIT_RST;
		end else if (cfg_we) begin
			if (cfg_index == CFG_MODE) begin
				mode_q <= cfg_data[2:0];
			end else begin
				limit_q <= cfg_data;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			cnt_q  <= '0;
			k_q    <= '0;
		end else begin
			k_q <= k_d;
			if (cmd.append) begin
				head_q <= (head_q == AW'(HIST_DEPTH - 1)) ? '0 : head_q + AW'(1);
				if (cnt_q < CW'(HIST_DEPTH)) begin
					cnt_q <= cnt_q + CW'(1);
				end
			end
		end
	end

	// address the entry k_d back from the newest; its data lands while k_q holds k_d
	always_comb begin
		k_d = k_q;
		if (cmd.k_clr) begin
			k_d = '0;
		end else if (cmd.k_inc) begin
			k_d = k_q + AW'(1);
		end
		slot = SW'(head_q) + SW'(HIST_DEPTH - 1) - SW'(k_d);
		if (slot >= SW'(HIST_DEPTH)) begin
			raddr = AW'(slot - SW'(HIST_DEPTH));
		end else begin
			raddr = AW'(slot);
		end
	end

	tpti_ram #(
		.WIDTH(64),
		.DEPTH(HIST_DEPTH)
	) u_hist (
		.clk  (clk),
		.we   (cmd.append),
		.waddr(head_q),
		.wdata(s_tdata),
		.raddr(raddr),
		.rdata(rdata)
	);

	assign rd_t  = rdata[31:0];
	assign rd_x  = rdata[47:32];
	assign rd_y  = rdata[63:48];
	assign d_now = (rd_t >= tq_q) ? rd_t - tq_q : tq_q - rd_t;

	assign div_num = (cmd.div_sel == DIV_LIMIT) ? NUM_W'({limit_q, 16'b0}) :
		{1'b0, adq_q, 16'b0} + NUM_W'(adt_q >> 1);

	tpti_div u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (cmd.div_start),
		.num   (div_num),
		.den   (adt_q),
		.busy  (div_busy),
		.quo   (div_quo)
	);

	assign q_ext = $signed({2'b00, div_quo});
	assign lo    = -26'sd65536 - lim_q;

	always_ff @(posedge clk) begin
		if (cmd.q_start) begin
			tq_q <= s_tdata[31:0];
		end
		if (cmd.res_zero) begin
			res_x_q <= '0;
			res_y_q <= '0;
			res_v_q <= 1'b0;
		end
		if (cmd.ld_new) begin
			ct_q    <= rd_t;
			cx_q    <= rd_x;
			cy_q    <= rd_y;
			res_x_q <= $signed({2'b00, rd_x});
			res_y_q <= $signed({2'b00, rd_y});
			res_v_q <= 1'b1;
		end
		if (cmd.nn_init) begin
			best_q <= d_now;
		end
		if (cmd.nn_take) begin
			best_q  <= d_now;
			res_x_q <= $signed({2'b00, rd_x});
			res_y_q <= $signed({2'b00, rd_y});
		end
		if (cmd.ld_prev) begin
			dt_q <= $signed({1'b0, ct_q}) - $signed({1'b0, rd_t});
			dq_q <= $signed({1'b0, tq_q}) - $signed({1'b0, ct_q});
			dx_q <= $signed({1'b0, cx_q}) - $signed({1'b0, rd_x});
			dy_q <= $signed({1'b0, cy_q}) - $signed({1'b0, rd_y});
		end
		if (cmd.prep) begin
			adt_q   <= dt_q[32] ? 32'(-dt_q) : dt_q[31:0];
			adq_q   <= dq_q[32] ? 32'(-dq_q) : dq_q[31:0];
			dtneg_q <= dt_q[32];
			fneg_q  <= dq_q[32] ^ dt_q[32];
		end
		if (cmd.f_zero) begin
			f_q <= '0;
		end
		if (cmd.ld_f) begin
			f_q <= fneg_q ? -q_ext : q_ext;
		end
		if (cmd.lim_cfg) begin
			lim_q <= $signed({2'b00, limit_q});
		end
		if (cmd.ld_lim) begin
			lim_q <= dtneg_q ? -q_ext : q_ext;
		end
		if (cmd.clamp) begin
			if (f_q > 26'sd0) begin
				if (f_q > lim_q) begin
					f_q <= lim_q;
				end
			end else if (f_q < lo) begin
				f_q <= lo;
			end
		end
		if (cmd.mul_x) begin
			p_s1 <= f_q * dx_q;
		end
		if (cmd.mul_y) begin
			p_s1 <= f_q * dy_q;
		end
		if (cmd.app_x) begin
			res_x_q <= apply(p_s1, cx_q);
		end
		if (cmd.app_y) begin
			res_y_q <= apply(p_s1, cy_q);
		end
		if (cmd.out_load) begin
			m_tdata_q <= {3'b000, res_v_q, res_y_q, res_x_q};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (cmd.out_load) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	assign sts.cnt_zero = cnt_q == '0;
	assign sts.cnt_lt2  = cnt_q < CW'(2);
	assign sts.mode     = mode_q;
	assign sts.nn_stop  = d_now >= best_q;
	assign sts.nn_last  = (CW'(k_q) + CW'(1)) == cnt_q;
	assign sts.dt_zero  = dt_q == '0;
	assign sts.div_busy = div_busy;
	assign sts.out_free = !m_tvalid_q || m_tready;

	`TPTI_ASSERT_IMPL(a_load_free, cmd.out_load, !m_tvalid_q || m_tready, "result overwrites pending item")
	`TPTI_ASSERT(a_cnt_range, cnt_q <= CW'(HIST_DEPTH), "history count beyond depth")
	`TPTI_ASSERT_IMPL(a_k_stored, cmd.k_inc, (CW'(k_q) + CW'(1)) < cnt_q, "walk past oldest entry")
	`TPTI_ASSERT_IMPL(a_div_idle, cmd.div_start, !div_busy, "divider restarted while busy")

endmodule

FILE: rtl/core/tpti_ctrl.sv
module tpti_ctrl import tpti_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	input  logic s_tuser,
	output logic s_tready,
	input  sts_t sts,
	output cmd_t cmd
);

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_CHK  = 4'd1;
	localparam logic [3:0] S_RN   = 4'd2;
	localparam logic [3:0] S_NN   = 4'd3;
	localparam logic [3:0] S_RP   = 4'd4;
	localparam logic [3:0] S_PREP = 4'd5;
	localparam logic [3:0] S_DFS  = 4'd6;
	localparam logic [3:0] S_DFW  = 4'd7;
	localparam logic [3:0] S_DLS  = 4'd8;
	localparam logic [3:0] S_DLW  = 4'd9;
	localparam logic [3:0] S_CLP  = 4'd10;
	localparam logic [3:0] S_MX   = 4'd11;
	localparam logic [3:0] S_MY   = 4'd12;
	localparam logic [3:0] S_AY   = 4'd13;
	localparam logic [3:0] S_DONE = 4'd14;

	logic [3:0] state_q;
	logic [3:0] state_d;

	assign s_tready = state_q == S_IDLE;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (s_tvalid) begin
					if (s_tuser == OP_QUERY) begin
						cmd.q_start = 1'b1;
						state_d     = S_CHK;
					end else begin
						cmd.append = 1'b1;
					end
				end
			end
			S_CHK: begin
				cmd.k_clr = 1'b1;
				if (sts.cnt_zero) begin
					cmd.res_zero = 1'b1;
					state_d      = S_DONE;
				end else begin
					state_d = S_RN;
				end
			end
			S_RN: begin
				cmd.ld_new = 1'b1;
				if (sts.cnt_lt2) begin
					state_d = S_DONE;
				end else begin
					case (sts.mode)
						MODE_NN: begin
							cmd.nn_init = 1'b1;
							cmd.k_inc   = 1'b1;
							state_d     = S_NN;
						end
						MODE_LIN, MODE_REL, MODE_ABS: begin
							cmd.k_inc = 1'b1;
							state_d   = S_RP;
						end
						default: state_d = S_DONE;
					endcase
				end
			end
			S_NN: begin
				// stop once the distance no longer shrinks or the oldest is reached
				if (sts.nn_stop) begin
					state_d = S_DONE;
				end else begin
					cmd.nn_take = 1'b1;
					if (sts.nn_last) begin
						state_d = S_DONE;
					end else begin
						cmd.k_inc = 1'b1;
					end
				end
			end
			S_RP: begin
				cmd.ld_prev = 1'b1;
				state_d     = S_PREP;
			end
			S_PREP: begin
				cmd.prep = 1'b1;
				if (sts.dt_zero) begin
					cmd.f_zero = 1'b1;
					state_d    = S_MX;
				end else begin
					state_d = S_DFS;
				end
			end
			S_DFS: begin
				cmd.div_start = 1'b1;
				cmd.div_sel   = DIV_FACTOR;
				state_d       = S_DFW;
			end
			S_DFW: begin
				if (!sts.div_busy) begin
					cmd.ld_f = 1'b1;
					if (sts.mode == MODE_ABS) begin
						state_d = S_DLS;
					end else if (sts.mode == MODE_REL) begin
						cmd.lim_cfg = 1'b1;
						state_d     = S_CLP;
					end else begin
						state_d = S_MX;
					end
				end
			end
			S_DLS: begin
				cmd.div_start = 1'b1;
				cmd.div_sel   = DIV_LIMIT;
				state_d       = S_DLW;
			end
			S_DLW: begin
				if (!sts.div_busy) begin
					cmd.ld_lim = 1'b1;
					state_d    = S_CLP;
				end
			end
			S_CLP: begin
				cmd.clamp = 1'b1;
				state_d   = S_MX;
			end
			S_MX: begin
				cmd.mul_x = 1'b1;
				state_d   = S_MY;
			end
			S_MY: begin
				cmd.app_x = 1'b1;
				cmd.mul_y = 1'b1;
				state_d   = S_AY;
			end
			S_AY: begin
				cmd.app_y = 1'b1;
				state_d   = S_DONE;
			end
			S_DONE: begin
				// hold until the output register is free
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

FILE: rtl/core/track_point_time_interpolator.sv
// Track point time interpolator.
// Input channel s_*: s_tuser selects the operation (0 append, 1 query);
// s_tdata carries the timestamp and, for appends, the Q12.4 position.
// An append is written to the history RAM as it is accepted; it gives
// no result. A query gives one item on m_*: the saturated position and a
// flag that the history held a sample.
// A query with an empty history, with one sample or in mode none ends without
// interpolation. Nearest neighbour walks back from the newest sample, one RAM
// read a cycle. The linear modes skip the divide when the two newest times
// are equal; else the radix-2 divider runs once for the factor and, in absolute
// limit mode, once more for the time limit; the relative limit mode takes its
// limit from the limit register.
// One query is in work at a time; s_tready is low until it is done.
// The output register holds a finished item while m_tready is low; the block
// then takes the next item and stalls only if a second result is ready.
// Reset empties the history, sets mode none and limit 1.0 in Q8.16; the RAM
// itself is not cleared. Configuration is written on cfg_we, index 0 mode,
// index 1 limit.
module track_point_time_interpolator import tpti_pkg::*; #(
	parameter int HIST_DEPTH = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [63:0] s_tdata,  // sample_time[31:0], pos_x[47:32], pos_y[63:48]
	input  logic        s_tuser,  // op
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,  // out_x[17:0], out_y[35:18], out_valid[36], zero fill
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [23:0] cfg_data
);

	cmd_t cmd;
	sts_t sts;

	tpti_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tuser (s_tuser),
		.s_tready(s_tready),
		.sts     (sts),
		.cmd     (cmd)
	);

	tpti_dpath #(
		.HIST_DEPTH(HIST_DEPTH)
	) u_dpath (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.sts      (sts),
		.s_tdata  (s_tdata),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.m_tready (m_tready),
		.m_tvalid (m_tvalid),
		.m_tdata  (m_tdata)
	);

endmodule
